// ===== src/vector_distance_l2_cosine_macros.svh =====
// Assertion macros for the vector distance scorer.
`ifndef VECTOR_DISTANCE_L2_COSINE_MACROS_SVH
`define VECTOR_DISTANCE_L2_COSINE_MACROS_SVH
`ifndef SYNTHESIS
`define VDC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VDC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define VDC_ASSERT(label, clk, rst_n, prop, msg)
`define VDC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/vdc_pkg.sv =====
// ----------------------------------------------------------------------------
// vdc_pkg
// Shared types and constants of the vector distance scorer.
// ----------------------------------------------------------------------------
package vdc_pkg;
	localparam int ELEM_W      = 16;
	localparam int DSQ_W       = 44;
	localparam int DOT_W       = 42;
	localparam int NORM_W      = 41;
	localparam int SCORE_W     = 23;
	localparam int IDX_W       = 16;
	localparam int MAX_DIM_DEF = 1024;
	localparam int MAX_VEC_DEF = 65536;
	localparam int FIFO_DEPTH  = 2;

	localparam logic METRIC_L2  = 1'b0;
	localparam logic METRIC_COS = 1'b1;

	// job handed from the front to the back
	typedef struct packed {
		logic              metric;
		logic [DSQ_W-1:0]  dsq;
		logic [DOT_W-1:0]  dot;
		logic [NORM_W-1:0] qn;
		logic [NORM_W-1:0] cn;
		logic [IDX_W-1:0]  idx;
	} job_t;
endpackage

// ===== src/vector_distance_l2_cosine.sv =====
// ----------------------------------------------------------------------------
// vector_distance_l2_cosine
// Euclidean distance or cosine similarity scorer over streamed vector pairs.
// ----------------------------------------------------------------------------
// channel | signals                                          | handshake
// input   | query_element candidate_element last_element ... | push / full
// result  | score candidate_index                            | pop / empty
// config  | metric_we metric_wdata                           | write enable
//
// The front takes one item per cycle and stalls only while the job queue is
// full or a staged job meets a non-empty queue. Each last item hands one job
// to the back, which runs restoring square roots on one shared root unit and
// the divide, one bit per cycle.
// Reset clears accumulators, counter, metric and queues asynchronously.
// ----------------------------------------------------------------------------
module vector_distance_l2_cosine import vdc_pkg::*; #(
	parameter int MAX_VECTORS = MAX_VEC_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic signed [ELEM_W-1:0]  query_element,
	input  logic signed [ELEM_W-1:0]  candidate_element,
	input  logic                      last_element,
	input  logic                      new_batch,
	output logic                      empty,
	input  logic                      pop,
	output logic signed [SCORE_W-1:0] score,
	output logic [IDX_W-1:0]          candidate_index,
	input  logic                      metric_we,
	input  logic                      metric_wdata
);
	logic metric_q;
	logic in_take;
	logic f_valid, q_empty, q_full, q_rd;
	job_t f_job, q_job;

	// hold the metric register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) metric_q <= METRIC_L2;
		else if (metric_we) metric_q <= metric_wdata;
	end

	// stall input while a job might not fit: one slot kept for the staged job
	assign full    = q_full || (f_valid && !q_empty);
	assign in_take = push && !full;

	vdc_front #(.MAX_VECTORS(MAX_VECTORS)) u_front (
		.clk, .arst_n, .in_take,
		.q_el(query_element), .c_el(candidate_element),
		.last(last_element), .nb(new_batch), .metric(metric_q),
		.job_valid(f_valid), .job(f_job)
	);

	vdc_fifo u_fifo (
		.clk, .arst_n, .wr(f_valid), .wdata(f_job),
		.rd(q_rd), .rdata(q_job), .empty(q_empty), .full(q_full)
	);

	vdc_back u_back (
		.clk, .arst_n, .job_valid(!q_empty), .job(q_job), .job_take(q_rd),
		.score, .index(candidate_index), .empty, .pop
	);
endmodule

// ===== src/vdc_front.sv =====
// ----------------------------------------------------------------------------
// vdc_front
// Accumulates element pairs and emits one job per candidate.
// ----------------------------------------------------------------------------
module vdc_front import vdc_pkg::*; #(
	parameter int MAX_VECTORS = MAX_VEC_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_take,
	input  logic signed [ELEM_W-1:0] q_el,
	input  logic signed [ELEM_W-1:0] c_el,
	input  logic                     last,
	input  logic                     nb,
	input  logic                     metric,
	output logic                     job_valid,
	output job_t                     job
);
	localparam logic [DSQ_W-1:0]  DSQ_MAX  = {DSQ_W{1'b1}};
	localparam logic [NORM_W-1:0] NORM_MAX = {NORM_W{1'b1}};
	localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
	localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
	localparam logic [IDX_W:0] VEC_LIM = (IDX_W+1)'(MAX_VECTORS);

	logic [DSQ_W-1:0]  dsq_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [NORM_W-1:0] qn_q, cn_q;
	logic [IDX_W-1:0]  cnt_q;

	logic signed [ELEM_W:0] diff;
	logic [ELEM_W:0] ad, aq, ac;
	logic [DSQ_W:0]  dsq_n;
	logic [NORM_W:0] qn_n, cn_n;
	logic signed [DOT_W:0] dot_n;
	logic [DSQ_W-1:0]  dsq_s;
	logic [NORM_W-1:0] qn_s, cn_s;
	logic signed [DOT_W-1:0] dot_s;
	logic [IDX_W-1:0] cnt_cur;
	logic [IDX_W:0]   cnt_inc;

	always_comb begin
		diff  = (ELEM_W+1)'(q_el) - (ELEM_W+1)'(c_el);
		ad    = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;
		aq    = q_el[ELEM_W-1] ? (ELEM_W+1)'(-(ELEM_W+1)'(q_el)) : (ELEM_W+1)'(q_el);
		ac    = c_el[ELEM_W-1] ? (ELEM_W+1)'(-(ELEM_W+1)'(c_el)) : (ELEM_W+1)'(c_el);
		dsq_n = (DSQ_W+1)'(dsq_q) + (DSQ_W+1)'(ad * ad);
		qn_n  = (NORM_W+1)'(qn_q) + (NORM_W+1)'(aq * aq);
		cn_n  = (NORM_W+1)'(cn_q) + (NORM_W+1)'(ac * ac);
		dot_n = (DOT_W+1)'(dot_q) + (DOT_W+1)'(q_el * c_el);
		dsq_s = dsq_n[DSQ_W] ? DSQ_MAX : dsq_n[DSQ_W-1:0];
		qn_s  = qn_n[NORM_W] ? NORM_MAX : qn_n[NORM_W-1:0];
		cn_s  = cn_n[NORM_W] ? NORM_MAX : cn_n[NORM_W-1:0];
		if (dot_n[DOT_W] != dot_n[DOT_W-1])
			dot_s = dot_n[DOT_W] ? DOT_MIN : DOT_MAX;
		else
			dot_s = dot_n[DOT_W-1:0];
		cnt_cur = nb ? '0 : cnt_q;
		cnt_inc = (IDX_W+1)'(cnt_cur) + (IDX_W+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsq_q <= '0; dot_q <= '0; qn_q <= '0; cn_q <= '0; cnt_q <= '0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= in_take && last;
			if (in_take) begin
				if (last) begin
					dsq_q <= '0; dot_q <= '0; qn_q <= '0; cn_q <= '0;
					cnt_q <= (cnt_inc >= VEC_LIM) ? '0 : cnt_inc[IDX_W-1:0];
				end else begin
					dsq_q <= dsq_s; dot_q <= dot_s; qn_q <= qn_s; cn_q <= cn_s;
					cnt_q <= cnt_cur;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && last) begin
			job.metric <= metric;
			job.dsq <= dsq_s;
			job.dot <= dot_s;
			job.qn  <= qn_s;
			job.cn  <= cn_s;
			job.idx <= cnt_cur;
		end
	end
endmodule

// ===== src/vdc_fifo.sv =====
// ----------------------------------------------------------------------------
// vdc_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`include "vector_distance_l2_cosine_macros.svh"
module vdc_fifo import vdc_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  job_t wdata,
	input  logic rd,
	output job_t rdata,
	output logic empty,
	output logic full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (AW+1)'(DEPTH));
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	`VDC_ASSERT_NEVER(a_no_overflow, clk, arst_n, wr && full && !rd, "job queue overflow")
	`VDC_ASSERT_NEVER(a_no_underflow, clk, arst_n, rd && empty, "job queue underflow")
	`VDC_ASSERT(a_count_range, clk, arst_n, cnt_q <= (AW+1)'(DEPTH), "job count out of range")
endmodule

// ===== src/vdc_back.sv =====
// ----------------------------------------------------------------------------
// vdc_back
// Square roots and the cosine divide, one bit a cycle; holds the result.
// ----------------------------------------------------------------------------
`include "vector_distance_l2_cosine_macros.svh"
module vdc_back import vdc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      job_valid,
	input  job_t                      job,
	output logic                      job_take,
	output logic signed [SCORE_W-1:0] score,
	output logic [IDX_W-1:0]          index,
	output logic                      empty,
	input  logic                      pop
);
	localparam int RW = 64;
	localparam int SW = 32;
	localparam int CW = 6;
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ1  = 3'd1;
	localparam logic [2:0] ST_SQ2  = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [14:0] QMAX = 15'h7fff;

	logic [2:0]    st_q;
	job_t          job_q;
	logic [RW-1:0] x_q, res_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] rq_q, rc_q;
	logic [RW-1:0] d_q, r_q;
	logic [14:0]   quo_q;
	logic          full_q;

	logic [RW-1:0] bitv, trial;
	logic          ge;
	logic [RW-1:0] sq_x, sq_r;
	logic [DOT_W-1:0] dot_neg;
	logic [RW-1:0] absdot, r_sh;
	logic [RW-1:0] rq_next;

	assign job_take = (st_q == ST_IDLE) && job_valid;
	assign empty    = !full_q;

	always_comb begin
		bitv  = RW'(1) << {n_q, 1'b0};
		trial = res_q + bitv;
		ge    = x_q >= trial;
		sq_x  = ge ? x_q - trial : x_q;
		sq_r  = ge ? (res_q >> 1) + bitv : res_q >> 1;
		// negate at the accumulator width so the most negative sum maps to 2^41
		dot_neg = -job_q.dot;
		absdot = job_q.dot[DOT_W-1] ? RW'(dot_neg) : RW'(job_q.dot);
		r_sh   = {r_q[RW-2:0], 1'b0};
		rq_next = RW'(rq_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			full_q <= 1'b0;
		end else begin
			if (st_q == ST_OUT && (!full_q || pop))
				full_q <= 1'b1;
			else if (pop)
				full_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (job_valid) st_q <= ST_SQ1;
				ST_SQ1: if (n_q == '0) st_q <= job_q.metric ? ST_SQ2 : ST_OUT;
				ST_SQ2: if (n_q == '0) st_q <= ST_MUL;
				ST_MUL: st_q <= ST_DIV;
				ST_DIV: if (n_q == '0) st_q <= ST_OUT;
				ST_OUT: if (!full_q || pop) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				job_q <= job;
				x_q   <= job.metric ? {3'b0, job.qn, 20'b0} : RW'(job.dsq);
				res_q <= '0;
				n_q   <= CW'(31);
			end
			ST_SQ1, ST_SQ2: begin
				if (n_q != '0) begin
					x_q <= sq_x; res_q <= sq_r;
					n_q <= n_q - CW'(1);
				end else if (st_q == ST_SQ1 && job_q.metric) begin
					rq_q  <= sq_r[SW-1:0];
					x_q   <= {3'b0, job_q.cn, 20'b0};
					res_q <= '0;
					n_q   <= CW'(31);
				end else begin
					x_q <= sq_x; res_q <= sq_r;
					if (st_q == ST_SQ2) rc_q <= sq_r[SW-1:0];
				end
			end
			ST_MUL: begin
				d_q   <= rq_next * RW'(rc_q);
				r_q   <= absdot << 20;
				quo_q <= '0;
				n_q   <= CW'(14);
			end
			ST_DIV: begin
				if (r_sh >= d_q) begin
					r_q <= r_sh - d_q; quo_q <= {quo_q[13:0], 1'b1};
				end else begin
					r_q <= r_sh; quo_q <= {quo_q[13:0], 1'b0};
				end
				if (n_q != '0) n_q <= n_q - CW'(1);
			end
			ST_OUT: begin
				if (!full_q || pop) begin
					index <= job_q.idx;
					if (!job_q.metric)
						score <= SCORE_W'(res_q);
					else if (rq_q == '0 || rc_q == '0)
						score <= '0;
					else if ((absdot << 20) >= d_q)
						score <= job_q.dot[DOT_W-1] ? -SCORE_W'(QMAX) : SCORE_W'(QMAX);
					else
						score <= job_q.dot[DOT_W-1] ? -SCORE_W'(quo_q) : SCORE_W'(quo_q);
				end
			end
			default: ;
		endcase
	end

	`VDC_ASSERT(a_take_idle, clk, arst_n, job_take |-> st_q == ST_IDLE, "job taken while busy")
	`VDC_ASSERT(a_out_load, clk, arst_n, $rose(full_q) |-> $past(st_q) == ST_OUT, "result without job")
	`VDC_ASSERT_NEVER(a_state_range, clk, arst_n, st_q > ST_OUT, "bad state")
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the L2 distance / cosine similarity scorer.
// A directed table, a few long full-scale vectors and about 900 random items
// stream through the push side. Every score popped is compared with a
// bit-true predictor kept in this file or with a value typed into the table.
// ----------------------------------------------------------------------------
module testbench;
	import vdc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int BACKEND_CYCLES = 120;  // covers one cosine job in the back end
	localparam int RANDOM_ITEMS   = 900;
	localparam int LONG_LEN       = 128;

	typedef struct {
		logic                      metric;
		logic signed [ELEM_W-1:0]  q;
		logic signed [ELEM_W-1:0]  c;
		logic                      last;
		logic                      nb;
		bit                        typed;
		int                        sc;
		int                        idx;
	} stim_row_t;

	typedef struct {
		logic signed [SCORE_W-1:0] sc;
		logic [IDX_W-1:0]          idx;
	} score_rec_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      push = 1'b0;
	logic                      full;
	logic signed [ELEM_W-1:0]  query_element = '0;
	logic signed [ELEM_W-1:0]  candidate_element = '0;
	logic                      last_element = 1'b0;
	logic                      new_batch = 1'b0;
	logic                      empty;
	logic                      pop = 1'b0;
	logic signed [SCORE_W-1:0] score;
	logic [IDX_W-1:0]          candidate_index;
	logic                      metric_we = 1'b0;
	logic                      metric_wdata = 1'b0;

	// predictor state
	longint unsigned    dsq_acc, qn_acc, cn_acc;
	longint             dot_acc;
	logic [IDX_W-1:0]   cand_cnt;
	logic               cur_metric;

	score_rec_t pending_scores[$];
	int         errors = 0;
	int         items_sent = 0;
	int         scores_seen = 0;
	int         l2_scores = 0;
	int         cos_scores = 0;
	int         send_idle = 0;
	int         recv_idle = 0;
	int         stall_cnt = 0;

	vector_distance_l2_cosine i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.query_element     (query_element),
		.candidate_element (candidate_element),
		.last_element      (last_element),
		.new_batch         (new_batch),
		.empty             (empty),
		.pop               (pop),
		.score             (score),
		.candidate_index   (candidate_index),
		.metric_we         (metric_we),
		.metric_wdata      (metric_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Floor square root, one result bit at a time from the top.
	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned r, t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= x)
				r = t;
		end
		return r;
	endfunction

	function automatic longint sat_add(longint unsigned a, longint unsigned b,
			longint unsigned lim);
		return (a + b > lim) ? lim : a + b;
	endfunction

	// Cosine in Q1.15: |dot| * 2^35 / (root(qn * 2^20) * root(cn * 2^20)).
	function automatic int cosine_q15();
		longint unsigned rq, rc, den, num;
		logic [79:0] quo;
		rq = floor_sqrt(qn_acc << 20);
		rc = floor_sqrt(cn_acc << 20);
		if (rq == 0 || rc == 0)
			return 0;
		den = rq * rc;
		num = (dot_acc < 0 ? -dot_acc : dot_acc) << 20;
		if (num >= den)
			quo = 32767;
		else
			quo = {num, 15'd0} / {16'd0, den};
		return dot_acc < 0 ? -int'(quo) : int'(quo);
	endfunction

	// Advance the predictor by one accepted item; return 1 when it scores.
	function automatic bit score_model(logic signed [ELEM_W-1:0] q,
			logic signed [ELEM_W-1:0] c, logic last, logic nb, output score_rec_t rec);
		longint qi, ci, d;
		qi = q;
		ci = c;
		d  = qi - ci;
		if (nb)
			cand_cnt = '0;
		dsq_acc = sat_add(dsq_acc, d * d, (64'd1 << DSQ_W) - 1);
		qn_acc  = sat_add(qn_acc, qi * qi, (64'd1 << NORM_W) - 1);
		cn_acc  = sat_add(cn_acc, ci * ci, (64'd1 << NORM_W) - 1);
		dot_acc = dot_acc + qi * ci;
		if (dot_acc > (64'sd1 <<< (DOT_W - 1)) - 1)
			dot_acc = (64'sd1 <<< (DOT_W - 1)) - 1;
		if (dot_acc < -(64'sd1 <<< (DOT_W - 1)))
			dot_acc = -(64'sd1 <<< (DOT_W - 1));
		if (!last)
			return 0;
		if (cur_metric == METRIC_L2) begin
			rec.sc = SCORE_W'(floor_sqrt(dsq_acc));
			l2_scores++;
		end else begin
			rec.sc = SCORE_W'(cosine_q15());
			cos_scores++;
		end
		rec.idx  = cand_cnt;
		cand_cnt = cand_cnt + 1'b1;
		dsq_acc  = 0;
		qn_acc   = 0;
		cn_acc   = 0;
		dot_acc  = 0;
		return 1;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] MISMATCH %s: got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Push one item, idling the sender at random first; hold until accepted.
	task automatic send_item(logic signed [ELEM_W-1:0] q, logic signed [ELEM_W-1:0] c,
			logic last, logic nb, bit typed, int t_sc, int t_idx);
		score_rec_t rec;
		score_rec_t typed_rec;
		if ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle)
				@(posedge clk);
		end
		push              <= 1'b1;
		query_element     <= q;
		candidate_element <= c;
		last_element      <= last;
		new_batch         <= nb;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		if (score_model(q, c, last, nb, rec)) begin
			if (typed) begin
				typed_rec.sc  = SCORE_W'(t_sc);
				typed_rec.idx = IDX_W'(t_idx);
				pending_scores.push_back(typed_rec);
			end else begin
				pending_scores.push_back(rec);
			end
		end
	endtask

	// Drop push, wait for every score, let the back end settle, then write.
	task automatic write_metric(logic m);
		push <= 1'b0;
		@(posedge clk);
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (BACKEND_CYCLES) @(posedge clk);
		metric_we    <= 1'b1;
		metric_wdata <= m;
		@(posedge clk);
		metric_we  <= 1'b0;
		cur_metric = m;
	endtask

	function automatic logic signed [ELEM_W-1:0] rand_element();
		case ($urandom_range(3))
			0: return ELEM_W'($urandom);
			1: return ELEM_W'(int'($urandom_range(1024)) - 512);
			2: case ($urandom_range(3))
				0: return 16'sh7fff;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'shffff;
			endcase
			default: return ELEM_W'(int'($urandom_range(8192)) - 4096);
		endcase
	endfunction

	// Receiver: pop at random, compare each score with the oldest prediction.
	always @(posedge clk) begin
		score_rec_t want;
		if (pop && !empty) begin
			scores_seen++;
			if (pending_scores.size() == 0) begin
				$display("[%0t] UNEXPECTED score %0d index %0d", $realtime, score,
					candidate_index);
				errors++;
			end else begin
				want = pending_scores.pop_front();
				if (score !== want.sc)
					report_mismatch("score", score, want.sc);
				if (candidate_index !== want.idx)
					report_mismatch("candidate_index", candidate_index, want.idx);
			end
		end
		pop <= ($urandom_range(99) >= recv_idle);
	end

	// Watchdog: count cycles with no item moving on either side.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= WATCHDOG_LIMIT) begin
			$display("[%0t] watchdog: no progress, %0d scores pending", $realtime,
				pending_scores.size());
			$display("** vector_distance_l2_cosine: FAILED **");
			$finish;
		end
	end

	// Directed rows; expected values typed in where they follow at a glance.
	stim_row_t directed[15] = '{
		// after reset: zero vector scores zero at index 0
		'{METRIC_L2,  16'sh0000,  16'sh0000, 1, 0, 1, 0,      0},
		// largest difference either way
		'{METRIC_L2,  16'sh7fff,  16'sh8000, 1, 0, 1, 65535,  1},
		'{METRIC_L2,  16'sh8000,  16'sh7fff, 1, 0, 1, 65535,  2},
		// batch restart in the middle of a vector keeps the sums
		'{METRIC_L2,  16'sd100,  -16'sd50,   0, 0, 0, 0,      0},
		'{METRIC_L2,  16'sd7,     16'sd3,    0, 1, 0, 0,      0},
		'{METRIC_L2, -16'sd1,     16'sd1,    1, 0, 0, 0,      0},
		'{METRIC_L2,  16'sh1000,  16'sh0000, 1, 1, 1, 4096,   0},
		// zero query norm gives zero similarity
		'{METRIC_COS, 16'sh0000,  16'sd5,    1, 0, 1, 0,      1},
		// parallel and anti-parallel clamp to full scale
		'{METRIC_COS, 16'sh1000,  16'sh1000, 1, 0, 1, 32767,  2},
		'{METRIC_COS, 16'sh1000, -16'sh1000, 1, 0, 1, -32767, 3},
		'{METRIC_COS, 16'sh8000,  16'sh8000, 1, 0, 1, 32767,  4},
		'{METRIC_COS, 16'sd3000,  16'sd1000, 0, 0, 0, 0,      0},
		'{METRIC_COS, -16'sd2000, 16'sd500,  1, 0, 0, 0,      0},
		// zero candidate norm
		'{METRIC_COS, 16'sd5,     16'sh0000, 1, 0, 1, 0,      6},
		'{METRIC_L2,  16'sd1,     16'sd1,    1, 0, 1, 0,      7}
	};

	initial begin
		logic nb;
		int len;
		logic signed [ELEM_W-1:0] qe, ce;

		dsq_acc    = 0;
		qn_acc     = 0;
		cn_acc     = 0;
		dot_acc    = 0;
		cand_cnt   = '0;
		cur_metric = METRIC_L2;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, no idling
		foreach (directed[i]) begin
			if (directed[i].metric != cur_metric)
				write_metric(directed[i].metric);
			send_item(directed[i].q, directed[i].c, directed[i].last, directed[i].nb,
				directed[i].typed, directed[i].sc, directed[i].idx);
		end

		// long vectors of full-scale elements grow every accumulator wide
		write_metric(METRIC_L2);
		for (int n = 0; n < 2 * LONG_LEN; n++)
			send_item(16'sh7fff, 16'sh8000, n == 2 * LONG_LEN - 1, 1'b0, 0, 0, 0);
		write_metric(METRIC_COS);
		for (int n = 0; n < LONG_LEN; n++)
			send_item(16'sh8000, 16'sh8000, n == LONG_LEN - 1, 1'b0, 0, 0, 0);
		for (int n = 0; n < LONG_LEN; n++)
			send_item(16'sh7fff, 16'sh8000, n == LONG_LEN - 1, 1'b0, 0, 0, 0);

		// random vectors in three idling phases, metric rewritten between them
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 32 : (ph == 1) ? 66 : 0;
			recv_idle = (ph == 0) ? 66 : (ph == 1) ? 32 : 0;
			write_metric(logic'($urandom_range(1)));
			for (int k = 0; k < RANDOM_ITEMS / 3; ) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(40, 9) :
					$urandom_range(8, 1);
				for (int e = 0; e < len; e++) begin
					qe = rand_element();
					// keep some candidates close to the query for high similarity
					ce = ($urandom_range(3) == 0) ? qe + ELEM_W'($urandom_range(15)) :
						rand_element();
					nb = ($urandom_range(24) == 0);
					send_item(qe, ce, e == len - 1, nb, 0, 0, 0);
				end
				k += len;
			end
		end

		// final drain, then allow the back end time for stray scores
		push <= 1'b0;
		@(posedge clk);
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (BACKEND_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d scores (%0d L2, %0d cosine), incl. long vectors",
			items_sent, scores_seen, l2_scores, cos_scores);
		$display("and batch restarts under three sender/receiver idling mixes.");
		if (errors == 0)
			$display("** vector_distance_l2_cosine: PASSED **");
		else
			$display("** vector_distance_l2_cosine: FAILED **");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+src
src/vdc_pkg.sv
src/vdc_front.sv
src/vdc_fifo.sv
src/vdc_back.sv
src/vector_distance_l2_cosine.sv
verif/testbench.sv
